// ----- design/sla_pkg.sv -----
// Package for the segment list allocator: status and opcode codes, sequencer states
// and default sizes. Used by the top level and by the testbench modules; sla_ram does not use it.
package sla_pkg;
    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int SIZE_BITS_DEF = 24;
    localparam logic [23:0] POOL_SIZE_RESET = 24'd65536;

    localparam logic [1:0] OP_FIRST = 2'd0;
    localparam logic [1:0] OP_BEST  = 2'd1;
    localparam logic [1:0] OP_WORST = 2'd2;
    localparam logic [1:0] OP_FREE  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [1:0] CFG_BASE   = 2'd0;
    localparam logic [1:0] CFG_SIZE   = 2'd1;
    localparam logic [1:0] CFG_ENABLE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHUP,
        S_SPLIT,
        S_MERGE,
        S_SHDN,
        S_DONE
    } state_t;
endpackage

// ----- design/sla_ram.sv -----
// Generic RAM with one write port and one registered read port, used for the segment table.
// Depends on nothing.
module sla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- design/segment_list_allocator_unit.sv -----
// Top level of the segment list allocator: sequencer, counters and segment table.
// Depends on sla_pkg and sla_ram.
// An item passes S_SCAN, which reads the entries one by one, then S_DECIDE and S_DONE; a split
// adds S_SHUP and S_SPLIT to shift the table up, and a merge adds S_MERGE and S_SHDN to shift it
// down. The table's one read port sets the pace of the scan and of the shifts.
// The block takes one item at a time; s_tready is low while an item is in
// work or its result waits. aresetn (synchronous, active low) gives pool_size 65536,
// disabled, one free segment.
module segment_list_allocator_unit
    import sla_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode[1:0], request_size[25:2], free_address[57:26], zero pad
    input  logic [63:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], block_address[33:2], allocated_bytes[57:34],
    // remaining_bytes[81:58], free_segment_count[88:82], alloc_success_count[120:89]
    output logic [127:0] m_tdata
);
    localparam int SIZE_BITS = SIZE_BITS_DEF;
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int EW = 2 * SIZE_BITS + 1;

    state_t state_reg, state_next;
    logic [31:0] base_reg;
    logic [23:0] size_reg;
    logic        en_reg;
    logic [CW-1:0] total_reg, free_reg;
    logic [SIZE_BITS-1:0] inuse_reg;
    logic [31:0] succ_reg;
    logic [1:0]  op_reg;
    logic [SIZE_BITS-1:0] need_reg;
    logic [31:0] addr_reg;
    logic [CW-1:0] idx_reg;
    logic        rv_reg;
    logic [IW-1:0] rptr_reg;
    logic        found_reg, done_scan_reg;
    logic [IW-1:0] pick_reg;
    logic [SIZE_BITS-1:0] plen_reg, poff_reg;
    logic        pused_reg;
    logic        prev_free_reg;
    logic [IW-1:0] prev_idx_reg;
    logic [SIZE_BITS-1:0] prev_len_reg;
    logic [1:0]  phase_reg;
    logic [CW-1:0] j_reg;
    logic [1:0]  st_reg;
    logic [31:0] oaddr_reg;
    logic        ovalid_reg;
    logic        init_reg;

    logic        we;
    logic [IW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic        r_used;
    logic [SIZE_BITS-1:0] r_len, r_off;

    sla_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_tab (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign r_used = rdata[EW-1];
    assign r_len  = rdata[2*SIZE_BITS-1:SIZE_BITS];
    assign r_off  = rdata[SIZE_BITS-1:0];
    assign s_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign m_tvalid = ovalid_reg;

    logic [SIZE_BITS-1:0] inuse_out;
    always_comb begin
        inuse_out = inuse_reg;
        m_tdata = '0;
        m_tdata[1:0] = st_reg;
        m_tdata[33:2] = oaddr_reg;
        m_tdata[57:34] = 24'(inuse_out);
        m_tdata[81:58] = size_reg - 24'(inuse_out);
        m_tdata[88:82] = 7'(free_reg);
        m_tdata[120:89] = succ_reg;
    end

    // Scan compare: one entry per cycle through a single compare unit.
    logic cand, better, exact, hit;
    logic [31:0] r_addr;
    always_comb begin
        r_addr = base_reg + 32'(r_off);
        cand = !r_used && (r_len >= need_reg);
        exact = cand && (r_len == need_reg);
        hit = (r_addr == addr_reg);
        better = 1'b0;
        unique case (op_reg)
            OP_FIRST: better = cand && !found_reg;
            OP_BEST:  better = cand && (!found_reg || r_len <= plen_reg);
            OP_WORST: better = cand && (!found_reg || r_len > plen_reg);
            OP_FREE:  better = hit && !found_reg;
            default:  better = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_tvalid && s_tready) state_next = S_SCAN;
            S_SCAN:   if (done_scan_reg) state_next = S_DECIDE;
            S_DECIDE: state_next = S_DONE;
            S_SHUP:   if (phase_reg == 2'd1 && j_reg <= CW'(pick_reg) + CW'(2))
                          state_next = S_SPLIT;
            S_SPLIT:  state_next = S_DONE;
            S_MERGE:  state_next = S_SHDN;
            S_SHDN:   if (j_reg + CW'(1) >= total_reg) state_next = S_DONE;
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
        if (state_reg == S_DECIDE) begin
            if (op_reg == OP_FREE) begin
                if (en_reg && found_reg && pused_reg) state_next = S_MERGE;
            end else if (en_reg && need_reg != '0 && found_reg
                         && plen_reg != need_reg && total_reg < CW'(MAX_SEGMENTS)) begin
                state_next = S_SHUP;
            end
        end
    end

    // Merge plan registers.
    logic [IW-1:0] mk_reg;
    logic [SIZE_BITS-1:0] mlen_reg, moff_reg;
    logic [CW-1:0] mrem_reg;
    logic        mprev_reg;

    always_comb begin
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = rptr_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (init_reg) begin
                    we = 1'b1;
                    waddr = '0;
                    wdata = {1'b0, SIZE_BITS'(size_reg), {SIZE_BITS{1'b0}}};
                end
            end
            S_SHUP: begin
                if (phase_reg == 2'd0) begin
                    raddr = IW'(j_reg - CW'(1));
                end else begin
                    raddr = IW'(j_reg - CW'(3));
                    we = 1'b1;
                    waddr = IW'(j_reg - CW'(1));
                    wdata = rdata;
                end
            end
            S_SPLIT: begin
                we = 1'b1;
                waddr = IW'(pick_reg + IW'(1));
                wdata = {1'b0, plen_reg - need_reg, poff_reg + need_reg};
            end
            S_MERGE: begin
                we = 1'b1;
                waddr = mk_reg;
                wdata = {1'b0, mlen_reg, moff_reg};
                raddr = IW'(j_reg + mrem_reg);
            end
            S_SHDN: begin
                raddr = IW'(j_reg + CW'(1) + mrem_reg);
                if (j_reg + mrem_reg < total_reg) begin
                    we = 1'b1;
                    waddr = IW'(j_reg);
                    wdata = rdata;
                end
            end
            S_DECIDE: begin
                if (op_reg != OP_FREE && en_reg && need_reg != '0 && found_reg
                    && (plen_reg == need_reg || total_reg < CW'(MAX_SEGMENTS))) begin
                    we = 1'b1;
                    waddr = pick_reg;
                    wdata = {1'b1, need_reg, poff_reg};
                end
            end
            default: ;
        endcase
    end

    // Lookahead for the merge: neighbor after the freed segment.
    logic [SIZE_BITS-1:0] next_len_reg;
    logic        next_free_reg, next_seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            base_reg <= '0;
            size_reg <= POOL_SIZE_RESET;
            en_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            init_reg <= 1'b1;
            total_reg <= CW'(1);
            free_reg <= CW'(1);
            inuse_reg <= '0;
            succ_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (init_reg) begin
                init_reg <= 1'b0;
            end
            if (cfg_we && cfg_index != 2'd3) begin
                unique case (cfg_index)
                    CFG_BASE:   base_reg <= cfg_wdata;
                    CFG_SIZE:   size_reg <= cfg_wdata[23:0];
                    CFG_ENABLE: en_reg <= cfg_wdata[0];
                    default:    ;
                endcase
                init_reg <= 1'b1;
                total_reg <= CW'(1);
                free_reg <= CW'(1);
                inuse_reg <= '0;
                succ_reg <= '0;
            end
            if (ovalid_reg && m_tready) ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        op_reg <= s_tdata[1:0];
                        need_reg <= SIZE_BITS'(s_tdata[25:2]);
                        addr_reg <= s_tdata[57:26];
                        rptr_reg <= '0;
                        idx_reg <= '0;
                        rv_reg <= 1'b0;
                        found_reg <= 1'b0;
                        done_scan_reg <= 1'b0;
                        prev_free_reg <= 1'b0;
                        next_seen_reg <= 1'b0;
                        next_free_reg <= 1'b0;
                    end
                end
                S_SCAN: begin
                    rv_reg <= 1'b1;
                    rptr_reg <= rptr_reg + IW'(1);
                    if (rv_reg && !done_scan_reg) begin
                        idx_reg <= idx_reg + CW'(1);
                        if (op_reg == OP_FREE && found_reg && !next_seen_reg) begin
                            next_seen_reg <= 1'b1;
                            next_free_reg <= !r_used;
                            next_len_reg <= r_len;
                        end
                        if (better) begin
                            found_reg <= 1'b1;
                            pick_reg <= IW'(idx_reg);
                            plen_reg <= r_len;
                            poff_reg <= r_off;
                            pused_reg <= r_used;
                        end
                        if (!(found_reg || better) || op_reg != OP_FREE) begin
                            prev_free_reg <= !r_used;
                            prev_idx_reg <= IW'(idx_reg);
                            prev_len_reg <= r_len;
                        end
                        if (idx_reg + CW'(1) >= total_reg
                            || (op_reg == OP_FIRST && better)
                            || (op_reg == OP_BEST && exact)
                            || (op_reg == OP_FREE && (found_reg || better) && next_seen_reg)
                            || (op_reg == OP_FREE && found_reg)) begin
                            done_scan_reg <= 1'b1;
                            rptr_reg <= rptr_reg;
                        end
                        if (idx_reg + CW'(1) >= total_reg) next_seen_reg <= 1'b1;
                    end
                    if (done_scan_reg) rv_reg <= 1'b0;
                end
                S_DECIDE: begin
                    st_reg <= ST_OK;
                    oaddr_reg <= '0;
                    if (op_reg == OP_FREE) begin
                        if (!(en_reg && found_reg && pused_reg)) begin
                            st_reg <= ST_BADFREE;
                        end else begin
                            inuse_reg <= inuse_reg - plen_reg;
                            mprev_reg <= prev_free_reg;
                            mk_reg <= prev_free_reg ? prev_idx_reg : pick_reg;
                            moff_reg <= prev_free_reg ? (poff_reg - prev_len_reg) : poff_reg;
                            mlen_reg <= plen_reg + (prev_free_reg ? prev_len_reg : '0)
                                        + (next_free_reg ? next_len_reg : '0);
                            mrem_reg <= CW'(prev_free_reg) + CW'(next_free_reg);
                            j_reg <= (prev_free_reg ? CW'(prev_idx_reg) : CW'(pick_reg))
                                     + CW'(1);
                            free_reg <= free_reg + CW'(1) - CW'(prev_free_reg)
                                        - CW'(next_free_reg);
                        end
                    end else if (!en_reg || need_reg == '0 || !found_reg) begin
                        st_reg <= ST_NOFIT;
                    end else if (plen_reg != need_reg && total_reg >= CW'(MAX_SEGMENTS)) begin
                        st_reg <= ST_FULL;
                    end else begin
                        oaddr_reg <= base_reg + 32'(poff_reg);
                        inuse_reg <= inuse_reg + need_reg;
                        succ_reg <= succ_reg + 32'd1;
                        if (plen_reg == need_reg) free_reg <= free_reg - CW'(1);
                        j_reg <= total_reg;
                        phase_reg <= 2'd0;
                    end
                end
                S_SHUP: begin
                    if (phase_reg == 2'd0) begin
                        if (j_reg <= CW'(pick_reg) + CW'(1)) begin
                            phase_reg <= 2'd1;
                            j_reg <= CW'(pick_reg) + CW'(2);
                        end else begin
                            phase_reg <= 2'd1;
                            j_reg <= j_reg + CW'(1);
                        end
                    end else begin
                        j_reg <= j_reg - CW'(1);
                    end
                end
                S_SPLIT: total_reg <= total_reg + CW'(1);
                S_MERGE: ;
                S_SHDN: begin
                    j_reg <= j_reg + CW'(1);
                    if (j_reg + CW'(1) >= total_reg) total_reg <= total_reg - mrem_reg;
                end
                S_DONE: ovalid_reg <= 1'b1;
                default: ;
            endcase
        end
    end
endmodule

// ----- dv/sla_checker.sv -----
// Result checker for the segment list allocator: watches the config port and both
// channels, keeps its own copy of the segment table and compares every result item.
// Depends on sla_pkg.
`timescale 1ns / 1ps

module sla_checker
    import sla_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [63:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    output int           mismatches,
    output int           outstanding
);
    typedef struct packed {
        logic [31:0] success;
        logic [6:0]  free_cnt;
        logic [23:0] remaining;
        logic [23:0] allocated;
        logic [31:0] address;
        logic [1:0]  status;
    } alloc_result_t;

    localparam int NSEG = MAX_SEGMENTS_DEF;

    logic [31:0] base_q;
    logic [23:0] size_q;
    logic        enable_q;
    logic [23:0] seg_off [NSEG];
    logic [23:0] seg_len [NSEG];
    logic        seg_used [NSEG];
    int          seg_total;
    logic [23:0] in_use;
    logic [6:0]  free_segs;
    logic [31:0] alloc_ok;

    alloc_result_t pending_results[$];

    function automatic void table_clear();
        for (int i = 0; i < NSEG; i++) begin
            seg_off[i] = '0;
            seg_len[i] = '0;
            seg_used[i] = 1'b0;
        end
        seg_len[0] = size_q;
        seg_total = 1;
        in_use = '0;
        free_segs = 7'd1;
        alloc_ok = '0;
    endfunction

    function automatic void drop_entry(int k);
        for (int j = k; j + 1 < seg_total; j++) begin
            seg_off[j] = seg_off[j + 1];
            seg_len[j] = seg_len[j + 1];
            seg_used[j] = seg_used[j + 1];
        end
        seg_total--;
    endfunction

    function automatic int pick_segment(logic [1:0] op, logic [23:0] need);
        int pick;
        pick = -1;
        for (int i = 0; i < seg_total; i++) begin
            if (seg_used[i] || seg_len[i] < need) continue;
            if (op == OP_FIRST) return i;
            if (op == OP_BEST) begin
                if (seg_len[i] == need) return i;
                if (pick < 0 || seg_len[i] <= seg_len[pick]) pick = i;
            end else if (pick < 0 || seg_len[i] > seg_len[pick]) begin
                pick = i;
            end
        end
        return pick;
    endfunction

    function automatic logic [1:0] do_alloc(logic [1:0] op, logic [23:0] need,
                                            output logic [31:0] addr);
        int i;
        addr = '0;
        if (!enable_q || need == 0) return ST_NOFIT;
        i = pick_segment(op, need);
        if (i < 0) return ST_NOFIT;
        if (seg_len[i] != need) begin
            if (seg_total >= NSEG) return ST_FULL;
            for (int j = seg_total; j > i + 1; j--) begin
                seg_off[j] = seg_off[j - 1];
                seg_len[j] = seg_len[j - 1];
                seg_used[j] = seg_used[j - 1];
            end
            seg_off[i + 1] = seg_off[i] + need;
            seg_len[i + 1] = seg_len[i] - need;
            seg_used[i + 1] = 1'b0;
            seg_total++;
        end else begin
            free_segs--;
        end
        seg_len[i] = need;
        seg_used[i] = 1'b1;
        in_use = in_use + need;
        alloc_ok++;
        addr = base_q + {8'd0, seg_off[i]};
        return ST_OK;
    endfunction

    function automatic logic [1:0] do_release(logic [31:0] address);
        int i;
        if (!enable_q) return ST_BADFREE;
        for (i = 0; i < seg_total; i++)
            if (base_q + {8'd0, seg_off[i]} == address) break;
        if (i >= seg_total || !seg_used[i]) return ST_BADFREE;
        seg_used[i] = 1'b0;
        in_use = in_use - seg_len[i];
        free_segs++;
        if (i > 0 && !seg_used[i - 1]) begin
            seg_len[i - 1] = seg_len[i - 1] + seg_len[i];
            drop_entry(i);
            i--;
            free_segs--;
        end
        if (i + 1 < seg_total && !seg_used[i + 1]) begin
            seg_len[i] = seg_len[i] + seg_len[i + 1];
            drop_entry(i + 1);
            free_segs--;
        end
        return ST_OK;
    endfunction

    function automatic alloc_result_t allocator_step(logic [63:0] item);
        alloc_result_t r;
        logic [1:0]  op;
        logic [31:0] addr;
        op = item[1:0];
        addr = '0;
        if (op == OP_FREE) r.status = do_release(item[57:26]);
        else r.status = do_alloc(op, item[25:2], addr);
        r.address = (r.status == ST_OK) ? addr : 32'd0;
        r.allocated = in_use;
        r.remaining = size_q - in_use;
        r.free_cnt = free_segs;
        r.success = alloc_ok;
        return r;
    endfunction

    assign outstanding = pending_results.size();

    always @(posedge aclk) begin
        alloc_result_t got, want;
        if (!aresetn) begin
            base_q = '0;
            size_q = POOL_SIZE_RESET;
            enable_q = 1'b0;
            table_clear();
            pending_results.delete();
            mismatches = 0;
        end else begin
            if (cfg_we && cfg_index != 2'd3) begin
                case (cfg_index)
                    CFG_BASE: base_q = cfg_wdata;
                    CFG_SIZE: size_q = cfg_wdata[23:0];
                    default: enable_q = cfg_wdata[0];
                endcase
                table_clear();
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(allocator_step(s_tdata));
            if (m_tvalid && m_tready) begin
                got = m_tdata[120:0];
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result item %h", $time, got);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status != want.status) begin
                        $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                        mismatches++;
                    end
                    if (got.address != want.address) begin
                        $display("%0t: address exp %h got %h", $time, want.address, got.address);
                        mismatches++;
                    end
                    if (got.allocated != want.allocated) begin
                        $display("%0t: allocated exp %h got %h", $time, want.allocated,
                                 got.allocated);
                        mismatches++;
                    end
                    if (got.remaining != want.remaining) begin
                        $display("%0t: remaining exp %h got %h", $time, want.remaining,
                                 got.remaining);
                        mismatches++;
                    end
                    if (got.free_cnt != want.free_cnt) begin
                        $display("%0t: free count exp %0d got %0d", $time, want.free_cnt,
                                 got.free_cnt);
                        mismatches++;
                    end
                    if (got.success != want.success) begin
                        $display("%0t: success count exp %0d got %0d", $time, want.success,
                                 got.success);
                        mismatches++;
                    end
                end
            end
        end
    end
endmodule

// ----- dv/tb_segment_list_allocator_unit.sv -----
// Testbench top for segment_list_allocator_unit: clock, reset, config phases, request stimulus
// with bursts and stalls, and the verdict. Depends on sla_pkg, sla_checker and the unit.
`timescale 1ns / 1ps

module tb_segment_list_allocator_unit;
    import sla_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    int           mismatches;
    int           outstanding;

    logic [1:0]  sent_ops[$];
    logic [31:0] live_addrs[$];
    logic [23:0] cur_size;
    int          cycles = 0;
    int          burst_left = 0;

    always #5 aclk = ~aclk;

    segment_list_allocator_unit uut (.*);

    sla_checker u_checker (.*);

    always @(posedge aclk) begin
        logic [1:0] op;
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
        if (s_tvalid && s_tready) sent_ops.push_back(s_tdata[1:0]);
        if (m_tvalid && m_tready && sent_ops.size() > 0) begin
            op = sent_ops.pop_front();
            if (op != OP_FREE && m_tdata[1:0] == ST_OK) live_addrs.push_back(m_tdata[33:2]);
        end
    end

    // Receiver: random stall pattern, plus one long hold-off.
    always @(negedge aclk) begin
        int rx_cycles, mode_left, mode, hold_left;
        if (!aresetn) begin
            rx_cycles = 0;
            mode_left = 0;
            mode = 0;
            hold_left = 0;
            m_tready <= 1'b0;
        end else begin
            rx_cycles++;
            if (rx_cycles == 40000) hold_left = 3000;
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 400);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (mode == 0) begin
                m_tready <= 1'b1;
            end else if (mode == 1) begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end else begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    task automatic send_request(logic [1:0] op, logic [23:0] size, logic [31:0] addr);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, addr, size, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0 || sent_ops.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_pool(logic [31:0] base, logic [23:0] size, logic en);
        wait_drained();
        write_reg(CFG_BASE, base);
        write_reg(CFG_SIZE, {8'd0, size});
        write_reg(CFG_ENABLE, {31'd0, en});
        live_addrs.delete();
        cur_size = size;
    endtask

    task automatic random_request();
        int pick, k;
        logic [23:0] unit;
        unit = (cur_size >> 8) == 0 ? 24'd1 : (cur_size >> 8);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            send_request(2'($urandom_range(0, 2)), 24'($urandom_range(1, 8)) * unit, '0);
        end else if (pick < 90 && live_addrs.size() > 0) begin
            k = $urandom_range(0, live_addrs.size() - 1);
            send_request(OP_FREE, 24'($urandom), live_addrs[k]);
            live_addrs.delete(k);
        end else if (pick < 95) begin
            send_request(OP_FREE, 24'($urandom), $urandom);
        end else begin
            send_request(2'($urandom_range(0, 3)), 24'($urandom), $urandom);
        end
    endtask

    initial begin
        logic [31:0] base;
        logic [23:0] size;
        cur_size = POOL_SIZE_RESET;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_request(OP_FIRST, 24'd16, '0);
        send_request(OP_FREE, '0, 32'd0);

        set_pool(32'hFFFF_FF00, 24'h200, 1'b1);
        send_request(OP_FIRST, 24'd0, '0);
        send_request(OP_BEST, 24'hFF_FFFF, '0);
        send_request(OP_FIRST, 24'h10, '0);
        send_request(OP_BEST, 24'h100, '0);
        send_request(OP_WORST, 24'h20, '0);
        send_request(OP_FREE, '0, 32'hFFFF_FF10);
        send_request(OP_FREE, '0, 32'hFFFF_FF10);
        send_request(OP_FREE, '0, 32'hFFFF_FFFF);
        send_request(OP_BEST, 24'h100, '0);
        send_request(OP_BEST, 24'h10, '0);
        send_request(OP_FREE, '0, 32'hFFFF_FF00);
        send_request(OP_FREE, '0, 32'h0000_0010);
        send_request(OP_WORST, 24'h1D0, '0);
        send_request(OP_FREE, '0, 32'hFFFF_FF10);

        set_pool(32'h0, 24'd0, 1'b1);
        send_request(OP_FIRST, 24'd1, '0);
        set_pool(32'h1234_0000, 24'hFF_FFFF, 1'b1);
        send_request(OP_WORST, 24'hFF_FFFF, '0);
        send_request(OP_FREE, 24'hFF_FFFF, 32'h1234_0000);
        set_pool(32'h0, 24'd1, 1'b1);
        send_request(OP_BEST, 24'd1, '0);
        send_request(OP_FIRST, 24'd1, '0);

        for (int ph = 0; ph < 12; ph++) begin
            base = (ph % 3 == 0) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 4095)) : $urandom;
            size = (ph == 4) ? 24'hFF_FFFF : 24'($urandom_range(64, 8192));
            set_pool(base, size, ph != 7);
            for (int n = 0; n < 160; n++) begin
                if (ph == 5 && n == 80) wait_drained();
                random_request();
            end
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
